// File: sv/assert_macros.svh
// Assertion macros shared by the run state controller RTL.
// Included by files that check their own logic; needs a clock named clk and reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rsc_pkg.sv
// Types, codes and helper functions of the multicore run state controller.
// Has no dependencies; the controller, the tally and the testbench import it.
`default_nettype none

package rsc_pkg;

  typedef enum logic [1:0] {
    ST_HALT = 2'd0,
    ST_RUN  = 2'd1,
    ST_IDLE = 2'd2,
    ST_ERR  = 2'd3
  } run_state_t;

  typedef enum logic [2:0] {
    MODE_SET      = 3'd0,
    MODE_REPORT   = 3'd1,
    MODE_MAILBOX  = 3'd2,
    MODE_RELEASE  = 3'd3,
    MODE_HALT_ALL = 3'd4,
    MODE_INITIAL  = 3'd5,
    MODE_QUERY    = 3'd6
  } mode_t;

  typedef enum logic {
    CFG_ACTIVE_CORES  = 1'b0,
    CFG_RELEASE_MAGIC = 1'b1
  } cfg_index_t;

  localparam logic [7:0] CODE_HALT = 8'h01;
  localparam logic [7:0] CODE_RUN  = 8'h02;
  localparam logic [7:0] CODE_IDLE = 8'h03;
  localparam logic [7:0] CODE_ERR  = 8'hFF;

  localparam logic [3:0] ACTIVE_CORES_RESET = 4'd8;

  // Per-state totals over the active cores.
  typedef struct packed {
    logic [3:0] running;
    logic [3:0] halted;
    logic [3:0] idle;
    logic [3:0] error;
  } rsc_counts_t;

  function automatic logic [7:0] code_of(input run_state_t s);
    logic [7:0] c;
    unique case (s)
      ST_HALT: c = CODE_HALT;
      ST_RUN:  c = CODE_RUN;
      ST_IDLE: c = CODE_IDLE;
      default: c = CODE_ERR;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/rsc_interfaces.sv
// Valid/ready channel interfaces of the run state controller: command, result
// and configuration write. No dependencies.
`default_nettype none

interface rsc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  core_index;
  logic [1:0]  new_state;
  logic [31:0] mailbox_word;
  modport source (output valid, mode, core_index, new_state, mailbox_word, input ready);
  modport sink (input valid, mode, core_index, new_state, mailbox_word, output ready);
endinterface

interface rsc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] state_code;
  logic       core_valid;
  logic       may_execute;
  logic       release_match;
  logic [2:0] freed_count;
  logic [3:0] running_count;
  logic [3:0] halted_count;
  logic [3:0] idle_count;
  logic [3:0] error_count;
  logic       all_idle;
  logic       release_done;
  modport source (output valid, state_code, core_valid, may_execute, release_match,
                  freed_count, running_count, halted_count, idle_count,
                  error_count, all_idle, release_done, input ready);
  modport sink (input valid, state_code, core_valid, may_execute, release_match,
                freed_count, running_count, halted_count, idle_count,
                error_count, all_idle, release_done, output ready);
endinterface

interface rsc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/multicore_run_state_controller.sv
// Run state controller for up to MAX_CORES cores: one command word in, one status word out.
// One command is accepted per cycle while status words are taken. It waits in the input
// register, where the read-modify-write of the per-core state registers and the state
// counts over the updated values are worked out, and its status word is loaded from there
// into the result register, from which it is offered to the result channel. A
// status word that waits holds the input register and, through it, command acceptance.
// Only core ids up to 14 are ever addressable, so at most 15 state entries are built.
// Configuration writes take effect at once and are accepted in every cycle.
`default_nettype none

`include "assert_macros.svh"

module multicore_run_state_controller
  import rsc_pkg::*;
#(
  parameter int MAX_CORES = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  rsc_cmd_if.sink    cmd,
  rsc_res_if.source  res,
  rsc_cfg_if.sink    cfg
);

  localparam int NUM   = (MAX_CORES < 15) ? MAX_CORES : 15;
  localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1;

  logic [3:0]  active_cores;
  logic [31:0] release_magic;

  run_state_t rs [NUM];
  run_state_t rs_next [NUM];
  logic armed, armed_next;
  logic taken, taken_next;

  logic        s1_valid;
  logic [2:0]  s1_mode;
  logic [3:0]  s1_core;
  logic [1:0]  s1_new_state;
  logic [31:0] s1_word;

  logic        out_valid;
  logic [7:0]  out_state_code;
  logic        out_core_valid;
  logic        out_may_execute;
  logic        out_match;
  logic [2:0]  out_released;
  rsc_counts_t out_counts;
  logic        out_done;

  logic        adv;
  logic [3:0]  n_eff;
  logic        core_ok;
  logic [IDX_W-1:0] idx;
  logic        match;
  logic [3:0]  rel_cnt;
  run_state_t  st;
  rsc_counts_t counts;

  logic [5:0]  count_sum;
  logic        release_go;
  logic        reads_err;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cores  <= ACTIVE_CORES_RESET;
      release_magic <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.index))
        CFG_ACTIVE_CORES:  active_cores  <= cfg.data[3:0];
        CFG_RELEASE_MAGIC: release_magic <= cfg.data;
        default: ;
      endcase
    end
  end

  assign adv       = s1_valid && (!out_valid || res.ready);
  assign cmd.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_mode      <= cmd.mode;
      s1_core      <= cmd.core_index;
      s1_new_state <= cmd.new_state;
      s1_word      <= cmd.mailbox_word;
    end
  end

  assign n_eff   = (active_cores > 4'(NUM)) ? 4'(NUM) : active_cores;
  assign core_ok = s1_core < n_eff;
  assign idx     = core_ok ? s1_core[IDX_W-1:0] : '0;

  always_comb begin
    rs_next    = rs;
    armed_next = armed;
    taken_next = taken;
    match      = 1'b0;
    rel_cnt    = '0;
    unique case (s1_mode)
      MODE_SET: begin
        if (core_ok) rs_next[idx] = run_state_t'(s1_new_state);
      end
      MODE_REPORT: begin
        if (core_ok && !(s1_core != 4'd0 && rs[idx] == ST_ERR)) begin
          rs_next[idx] = run_state_t'(s1_new_state);
        end
      end
      MODE_MAILBOX: begin
        match = (s1_word == release_magic);
        if (match) armed_next = 1'b1;
      end
      MODE_RELEASE: begin
        if (armed && !taken) begin
          for (int i = 1; i < NUM; i++) begin
            if (4'(i) < n_eff && rs[i] == ST_HALT) begin
              rs_next[i] = ST_RUN;
              rel_cnt    = rel_cnt + 4'd1;
            end
          end
          taken_next = 1'b1;
        end
      end
      MODE_HALT_ALL: begin
        for (int i = 0; i < NUM; i++) begin
          if (4'(i) < n_eff) rs_next[i] = ST_HALT;
        end
      end
      MODE_INITIAL: begin
        for (int i = 0; i < NUM; i++) begin
          rs_next[i] = (i == 0) ? ST_RUN : ST_HALT;
        end
        armed_next = 1'b0;
        taken_next = 1'b0;
      end
      default: ;
    endcase
  end

  rsc_tally #(.NUM(NUM)) u_tally (
    .states (rs_next),
    .live   (n_eff),
    .counts (counts)
  );

  assign st = core_ok ? rs_next[idx] : ST_ERR;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM; i++) begin
        rs[i] <= (i == 0) ? ST_RUN : ST_HALT;
      end
      armed <= 1'b0;
      taken <= 1'b0;
    end else if (adv) begin
      rs    <= rs_next;
      armed <= armed_next;
      taken <= taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state_code  <= code_of(st);
      out_core_valid  <= core_ok;
      out_may_execute <= (st == ST_RUN) || (st == ST_ERR && s1_core == 4'd0);
      out_match       <= match;
      out_released    <= (rel_cnt > 4'd7) ? 3'd7 : rel_cnt[2:0];
      out_counts      <= counts;
      out_done        <= taken_next;
    end
  end

  assign res.valid          = out_valid;
  assign res.state_code     = out_state_code;
  assign res.core_valid     = out_core_valid;
  assign res.may_execute    = out_may_execute;
  assign res.release_match  = out_match;
  assign res.freed_count    = out_released;
  assign res.running_count  = out_counts.running;
  assign res.halted_count   = out_counts.halted;
  assign res.idle_count     = out_counts.idle;
  assign res.error_count    = out_counts.error;
  assign res.all_idle       = (out_counts.running == 4'd0) && (out_counts.halted == 4'd0);
  assign res.release_done   = out_done;

  assign count_sum  = 6'(out_counts.running) + 6'(out_counts.halted) + 6'(out_counts.idle)
                    + 6'(out_counts.error);
  assign release_go = adv && (s1_mode == MODE_RELEASE) && armed;
  assign reads_err  = (out_state_code == CODE_ERR);

  `ASSERT_CLK(a_counts_cover_live, out_valid |-> (count_sum == 6'(n_eff)), "bad state totals")
  `ASSERT_CLK(a_release_sets_done, (out_valid && |out_released) |-> out_done, "no release done")
  `ASSERT_CLK(a_taken_by_release, $rose(taken) |-> $past(release_go), "release taken unarmed")
  `ASSERT_CLK(a_invalid_reads_error, out_valid && !out_core_valid |-> reads_err, "bad invalid read")

endmodule

`default_nettype wire

// File: sv/rsc_tally.sv
// Counts the active cores in each run state.
// Depends on rsc_pkg.
`default_nettype none

module rsc_tally
  import rsc_pkg::*;
#(
  parameter int NUM = 8
) (
  input  run_state_t  states [NUM],
  input  logic [3:0]  live,
  output rsc_counts_t counts
);

  always_comb begin
    counts = '0;
    for (int i = 0; i < NUM; i++) begin
      if (4'(i) < live) begin
        unique case (states[i])
          ST_HALT: counts.halted  = counts.halted + 4'd1;
          ST_RUN:  counts.running = counts.running + 4'd1;
          ST_IDLE: counts.idle    = counts.idle + 4'd1;
          default: counts.error   = counts.error + 4'd1;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench of the multicore run state controller: directed table, then random
// command words under three idle patterns, checked against an in-bench predictor or a row's own expected word.
// Depends on rsc_pkg, rsc_interfaces and multicore_run_state_controller.
`default_nettype none

module tb_top;
  import rsc_pkg::*;

  localparam int CORE_SLOTS = 8;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int RECONFIG_EVERY = 200;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] state_code;
    logic       core_valid;
    logic       may_execute;
    logic       release_match;
    logic [2:0] freed_count;
    logic [3:0] running_count;
    logic [3:0] halted_count;
    logic [3:0] idle_count;
    logic [3:0] error_count;
    logic       all_idle;
    logic       release_done;
  } core_status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  core;
    logic [1:0]  new_state;
    logic [31:0] word;
  } cmd_word_t;

  typedef struct {
    bit           is_cfg;
    cfg_index_t   reg_sel;
    logic [31:0]  cfg_data;
    cmd_word_t    cmd;
    bit           typed;
    core_status_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsc_cmd_if cmd_ch ();
  rsc_res_if res_ch ();
  rsc_cfg_if cfg_ch ();

  multicore_run_state_controller #(.MAX_CORES(CORE_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  run_state_t   core_state [CORE_SLOTS];
  bit           rel_armed;
  bit           rel_taken;
  logic [3:0]   cores_cfg;
  logic [31:0]  magic_cfg;

  core_status_t status_due [$];
  core_status_t predicted;
  core_status_t observed;
  core_status_t wanted;
  int           mismatches = 0;

  bit           cmd_typed = 1'b0;
  core_status_t cmd_want = '0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           phase_no = 0;
  logic         recv_hold = 1'b0;
  plan_row_t    plan [$];

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic void restore_initial();
    for (int i = 0; i < CORE_SLOTS; i++) core_state[i] = (i == 0) ? ST_RUN : ST_HALT;
    rel_armed = 1'b0;
    rel_taken = 1'b0;
  endfunction

  function automatic core_status_t apply_command(logic [2:0] mode, logic [3:0] core,
                                                 run_state_t ns, logic [31:0] word);
    int unsigned  n;
    bit           ok;
    int unsigned  moved;
    int unsigned  tally [4];
    run_state_t   st;
    core_status_t r;
    n = (cores_cfg > CORE_SLOTS) ? CORE_SLOTS : cores_cfg;
    ok = core < n;
    moved = 0;
    r = '0;
    foreach (tally[k]) tally[k] = 0;
    case (mode)
      MODE_SET: if (ok) core_state[core] = ns;
      MODE_REPORT: if (ok && !(core != 0 && core_state[core] == ST_ERR)) core_state[core] = ns;
      MODE_MAILBOX: begin
        r.release_match = (word == magic_cfg);
        if (r.release_match) rel_armed = 1'b1;
      end
      MODE_RELEASE: begin
        if (rel_armed && !rel_taken) begin
          for (int i = 1; i < n; i++) begin
            if (core_state[i] == ST_HALT) begin
              core_state[i] = ST_RUN;
              moved++;
            end
          end
          rel_taken = 1'b1;
        end
      end
      MODE_HALT_ALL: for (int i = 0; i < n; i++) core_state[i] = ST_HALT;
      MODE_INITIAL: restore_initial();
      default: ;
    endcase
    for (int i = 0; i < n; i++) tally[core_state[i]]++;
    st = ok ? core_state[core] : ST_ERR;
    case (st)
      ST_HALT: r.state_code = CODE_HALT;
      ST_RUN:  r.state_code = CODE_RUN;
      ST_IDLE: r.state_code = CODE_IDLE;
      default: r.state_code = CODE_ERR;
    endcase
    r.core_valid = ok;
    r.may_execute = (st == ST_RUN) || (st == ST_ERR && core == 0);
    r.freed_count = moved[2:0];
    r.running_count = tally[ST_RUN][3:0];
    r.halted_count = tally[ST_HALT][3:0];
    r.idle_count = tally[ST_IDLE][3:0];
    r.error_count = tally[ST_ERR][3:0];
    r.all_idle = (tally[ST_RUN] == 0) && (tally[ST_HALT] == 0);
    r.release_done = rel_taken;
    return r;
  endfunction

  function automatic void note_mismatch(string what, core_status_t want, core_status_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch: %s expected %p got %p", what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ACTIVE_CORES) cores_cfg = cfg_ch.data[3:0];
        else magic_cfg = cfg_ch.data;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted = apply_command(cmd_ch.mode, cmd_ch.core_index,
                                  run_state_t'(cmd_ch.new_state), cmd_ch.mailbox_word);
        status_due.push_back(cmd_typed ? cmd_want : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        observed.state_code = res_ch.state_code;
        observed.core_valid = res_ch.core_valid;
        observed.may_execute = res_ch.may_execute;
        observed.release_match = res_ch.release_match;
        observed.freed_count = res_ch.freed_count;
        observed.running_count = res_ch.running_count;
        observed.halted_count = res_ch.halted_count;
        observed.idle_count = res_ch.idle_count;
        observed.error_count = res_ch.error_count;
        observed.all_idle = res_ch.all_idle;
        observed.release_done = res_ch.release_done;
        if (status_due.size() == 0) begin
          note_mismatch("status word with none pending", '0, observed);
        end else begin
          wanted = status_due.pop_front();
          if (observed !== wanted) note_mismatch("status word", wanted, observed);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (phase_no == 3);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("multicore_run_state_controller verification failed");
    $finish;
  end

  task automatic send_command(cmd_word_t c, bit typed, core_status_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= c.mode;
    cmd_ch.core_index <= c.core;
    cmd_ch.new_state <= c.new_state;
    cmd_ch.mailbox_word <= c.word;
    cmd_typed <= typed;
    cmd_want <= want;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [31:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic core_status_t status(logic [7:0] code, logic valid, logic may,
                                          logic match, logic [2:0] moved, logic [3:0] run,
                                          logic [3:0] halt, logic [3:0] idle,
                                          logic [3:0] err, logic all_idle, logic done);
    return '{code, valid, may, match, moved, run, halt, idle, err, all_idle, done};
  endfunction

  function automatic plan_row_t cmd_row(logic [2:0] m, logic [3:0] c, run_state_t s,
                                        logic [31:0] w);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = CFG_ACTIVE_CORES;
    r.cfg_data = '0;
    r.cmd = '{m, c, s, w};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(logic [2:0] m, logic [3:0] c, run_state_t s,
                                          logic [31:0] w, core_status_t want);
    plan_row_t r;
    r = cmd_row(m, c, s, w);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_index_t idx, logic [31:0] value);
    plan_row_t r;
    r = cmd_row(MODE_QUERY, 4'd0, ST_HALT, 32'd0);
    r.is_cfg = 1'b1;
    r.reg_sel = idx;
    r.cfg_data = value;
    return r;
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    c.core = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    c.new_state = 2'($urandom_range(3));
    c.word = $urandom;
    if (pick < 25) c.mode = MODE_SET;
    else if (pick < 45) c.mode = MODE_REPORT;
    else if (pick < 55) begin
      c.mode = MODE_MAILBOX;
      if ($urandom_range(1) == 0) c.word = magic_cfg;
    end
    else if (pick < 63) c.mode = MODE_RELEASE;
    else if (pick < 68) c.mode = MODE_HALT_ALL;
    else if (pick < 73) c.mode = MODE_INITIAL;
    else if (pick < 93) c.mode = MODE_QUERY;
    else c.mode = MODE_UNUSED;
    return c;
  endfunction

  function automatic logic [3:0] pick_core_count();
    case ($urandom_range(4))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [31:0] pick_magic();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_QUERY;
    cmd_ch.core_index = '0;
    cmd_ch.new_state = '0;
    cmd_ch.mailbox_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ACTIVE_CORES;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    cores_cfg = ACTIVE_CORES_RESET;
    magic_cfg = '0;
    restore_initial();

    plan.push_back(typed_row(MODE_QUERY, 4'd0, ST_HALT, 32'd0,
                             status(CODE_RUN, 1, 1, 0, 0, 1, 7, 0, 0, 0, 0)));
    plan.push_back(typed_row(MODE_QUERY, 4'd15, ST_ERR, 32'd0,
                             status(CODE_ERR, 0, 0, 0, 0, 1, 7, 0, 0, 0, 0)));
    plan.push_back(cmd_row(MODE_MAILBOX, 4'd0, ST_HALT, 32'hFFFF_FFFF));
    plan.push_back(typed_row(MODE_MAILBOX, 4'd0, ST_HALT, 32'd0,
                             status(CODE_RUN, 1, 1, 1, 0, 1, 7, 0, 0, 0, 0)));
    plan.push_back(typed_row(MODE_RELEASE, 4'd1, ST_HALT, 32'd0,
                             status(CODE_RUN, 1, 1, 0, 7, 8, 0, 0, 0, 0, 1)));
    plan.push_back(cmd_row(MODE_RELEASE, 4'd2, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd7, ST_ERR, 32'd0));
    plan.push_back(cmd_row(MODE_REPORT, 4'd7, ST_RUN, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd0, ST_ERR, 32'd0));
    plan.push_back(cmd_row(MODE_REPORT, 4'd0, ST_IDLE, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd3, ST_IDLE, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd1, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_REPORT, 4'd12, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_UNUSED, 4'd3, ST_RUN, 32'h5A5A_A5A5));
    plan.push_back(cmd_row(MODE_HALT_ALL, 4'd5, ST_HALT, 32'd0));
    plan.push_back(typed_row(MODE_INITIAL, 4'd0, ST_HALT, 32'd0,
                             status(CODE_RUN, 1, 1, 0, 0, 1, 7, 0, 0, 0, 0)));
    plan.push_back(cmd_row(MODE_RELEASE, 4'd1, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd4, ST_IDLE, 32'd0));
    plan.push_back(cmd_row(MODE_MAILBOX, 4'd4, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_RELEASE, 4'd4, ST_HALT, 32'd0));
    plan.push_back(cfg_row(CFG_ACTIVE_CORES, 32'd0));
    plan.push_back(typed_row(MODE_INITIAL, 4'd0, ST_HALT, 32'd0,
                             status(CODE_ERR, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0)));
    plan.push_back(cfg_row(CFG_ACTIVE_CORES, 32'd15));
    plan.push_back(cmd_row(MODE_QUERY, 4'd7, ST_HALT, 32'd0));
    plan.push_back(cmd_row(MODE_SET, 4'd9, ST_RUN, 32'd0));
    plan.push_back(cfg_row(CFG_RELEASE_MAGIC, 32'hFFFF_FFFF));
    plan.push_back(cmd_row(MODE_MAILBOX, 4'd2, ST_HALT, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CFG_ACTIVE_CORES, 32'd1));
    plan.push_back(cmd_row(MODE_RELEASE, 4'd0, ST_HALT, 32'd0));

    send_idle_pct = 8;
    recv_idle_pct = 74;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_register(plan[i].reg_sel, plan[i].cfg_data);
      else send_command(plan[i].cmd, plan[i].typed, plan[i].want);
    end

    for (int p = 1; p <= 3; p++) begin
      send_idle_pct = (p == 1) ? 8 : (p == 2) ? 74 : 0;
      recv_idle_pct = (p == 1) ? 74 : (p == 2) ? 8 : 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % RECONFIG_EVERY == 0) begin
          write_register(CFG_ACTIVE_CORES, {28'($urandom), pick_core_count()});
          write_register(CFG_RELEASE_MAGIC, pick_magic());
        end
        if (k == 0) phase_no = p;
        send_command(random_command(), 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("multicore_run_state_controller verification clean");
    end else begin
      $display("multicore_run_state_controller verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_interfaces.sv
sv/rsc_tally.sv
sv/multicore_run_state_controller.sv
test/tb_top.sv
